FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/csb_pkg.sv
// shared types, constants and codes of the counting semaphore bank
package csb_pkg;

    // field widths of the channels
    localparam int FUNC_W     = 1;
    localparam int PID_FW     = 6;
    localparam int RES_FW     = 4;
    localparam int STATUS_W   = 2;

    // configuration port
    localparam int RC_W       = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int INIT_FIELDS = 8;
    localparam int INIT_FW    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_RESOURCE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COUNTS = 2'd1;
    localparam logic [RC_W-1:0]      RC_RESET           = 4'd8;

    // default sizes
    localparam int DEF_NUM_RESOURCES = 8;
    localparam int DEF_MAX_PIDS      = 64;
    localparam int DEF_QUEUE_DEPTH   = 64;

    // semaphore count and hold count ranges
    localparam int CNT_W  = 10;
    localparam int HOLD_W = 8;
    localparam logic signed [CNT_W-1:0] CNT_MAX  = 10'sh1FF;
    localparam logic signed [CNT_W-1:0] CNT_MIN  = 10'sh200;
    localparam logic signed [CNT_W-1:0] CNT_ONE  = 10'sh001;
    localparam logic signed [CNT_W-1:0] CNT_ZERO = 10'sh000;
    localparam logic [HOLD_W-1:0]       HOLD_MAX = 8'hFF;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_REQUEST = 1'b0;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BLOCKED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic clear_en;
        logic accept;
        logic commit;
        logic wake_write;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic out_free;
        logic wake_needed;
    } dp_status_t;

endpackage

FILE: rtl/core/csb_if.sv
// handshake channels for operation beats and result beats
interface csb_in_if
    import csb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [PID_FW-1:0] pid;
    logic [RES_FW-1:0] resource;

    modport source (output valid, output func, output pid, output resource, input ready);
    modport sink   (input valid, input func, input pid, input resource, output ready);
endinterface

interface csb_out_if
    import csb_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                woken_valid;
    logic [PID_FW-1:0]   woken_pid;

    modport source (output valid, output status, output woken_valid, output woken_pid,
                    input ready);
    modport sink   (input valid, input status, input woken_valid, input woken_pid,
                    output ready);
endinterface

FILE: rtl/core/counting_semaphore_bank.sv
// top level of the counting semaphore bank
//
//  channel  dir  handshake      payload
//  cmd      in   valid/ready    func, pid, resource
//  rsp      out  valid/ready    status, woken_valid, woken_pid
//  cfg      in   cfg_we         cfg_index, cfg_data
//
//  an operation passes through accept, then evaluate and write back (held while a
//  result beat waits in the result register); a release that wakes a process other
//  than the releaser adds a wake step, the second write to the single-write-port hold count memory
//  after reset a clearing pass zeroes all 2**(clog2(MAX_PIDS) + max(1, clog2(NUM_RESOURCES)))
//  hold count memory entries (512 by default), with cmd.ready low
//  the result register frees the evaluate step; a stalled rsp holds the next operation
module counting_semaphore_bank
    import csb_pkg::*;
#(
    parameter int NUM_RESOURCES = DEF_NUM_RESOURCES,
    parameter int MAX_PIDS      = DEF_MAX_PIDS,
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    csb_in_if.sink                cmd,
    csb_out_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    // sequencing
    csb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .status    (dp_status),
        .cmd       (ctrl_cmd)
    );

    // state and memories
    csb_datapath #(
        .NUM_RESOURCES (NUM_RESOURCES),
        .MAX_PIDS      (MAX_PIDS),
        .QUEUE_DEPTH   (QUEUE_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (ctrl_cmd),
        .status          (dp_status),
        .in_func         (cmd.func),
        .in_pid          (cmd.pid),
        .in_resource     (cmd.resource),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .rsp_valid       (rsp.valid),
        .rsp_ready       (rsp.ready),
        .rsp_status      (rsp.status),
        .rsp_woken_valid (rsp.woken_valid),
        .rsp_woken_pid   (rsp.woken_pid)
    );

endmodule

FILE: rtl/core/csb_ctrl.sv
// sequencing controller: clearing pass, accept, evaluate, wake write
module csb_ctrl
    import csb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EVAL  = 4'b0100,
        S_WAKE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and command strobes
    always_comb
    begin
        state_next     = state_reg;
        cmd.clear_en   = 1'b0;
        cmd.accept     = 1'b0;
        cmd.commit     = 1'b0;
        cmd.wake_write = 1'b0;
        cmd_ready      = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd_ready  = 1'b1;
                cmd.accept = cmd_valid;
                if (cmd_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                // wait here until the result register can take the beat
                cmd.commit = status.out_free;
                if (status.out_free)
                begin
                    state_next = status.wake_needed ? S_WAKE : S_IDLE;
                end
            end
            S_WAKE:
            begin
                cmd.wake_write = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

FILE: rtl/core/csb_datapath.sv
// semaphore counts, wait queue memory, hold count memory and result register
module csb_datapath
    import csb_pkg::*;
#(
    parameter int NUM_RESOURCES = DEF_NUM_RESOURCES,
    parameter int MAX_PIDS      = DEF_MAX_PIDS,
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    input  logic [FUNC_W-1:0]     in_func,
    input  logic [PID_FW-1:0]     in_pid,
    input  logic [RES_FW-1:0]     in_resource,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic [STATUS_W-1:0]   rsp_status,
    output logic                  rsp_woken_valid,
    output logic [PID_FW-1:0]     rsp_woken_pid
);

    localparam int RES_W   = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int PID_W   = $clog2(MAX_PIDS);
    localparam int SLOT_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = FILL_W + 1;
    localparam int HADDR_W = PID_W + RES_W;
    localparam int QADDR_W = RES_W + SLOT_W;
    localparam int HOLD_DEPTH  = 2 ** HADDR_W;
    localparam int QMEM_DEPTH  = 2 ** QADDR_W;

    function automatic logic [HOLD_W-1:0] hold_up(input logic [HOLD_W-1:0] h);
        return (h != HOLD_MAX) ? h + HOLD_W'(1) : h;
    endfunction

    function automatic logic [HOLD_W-1:0] hold_down(input logic [HOLD_W-1:0] h);
        return (h != '0) ? h - HOLD_W'(1) : h;
    endfunction

    // per-semaphore state
    logic signed [CNT_W-1:0] cnt_reg  [NUM_RESOURCES];
    logic [SLOT_W-1:0]       head_reg [NUM_RESOURCES];
    logic [FILL_W-1:0]       fill_reg [NUM_RESOURCES];
    logic [RC_W-1:0]         rc_reg;

    // memories
    logic [PID_FW-1:0] qmem [QMEM_DEPTH];
    logic [HOLD_W-1:0] hmem [HOLD_DEPTH];

    // captured beat and registered memory reads
    logic [FUNC_W-1:0] func_reg;
    logic [PID_FW-1:0] pid_reg;
    logic [RES_FW-1:0] res_reg;
    logic [PID_FW-1:0] qrd_reg;
    logic [HOLD_W-1:0] hrd_a_reg;
    logic [HOLD_W-1:0] hrd_b_reg;
    logic [HADDR_W-1:0] clr_addr_reg;

    // result register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_wv_reg;
    logic [PID_FW-1:0]   out_wpid_reg;

    // evaluation signals
    logic [RES_W-1:0]        rsel;
    logic                    res_ok;
    logic                    is_req;
    logic signed [CNT_W-1:0] cur_cnt;
    logic signed [CNT_W-1:0] inc_cnt;
    logic [SLOT_W-1:0]       cur_head;
    logic [FILL_W-1:0]       cur_fill;
    logic                    grant;
    logic                    full;
    logic                    wake;
    logic                    pid_ok;
    logic                    wpid_ok;
    logic [SUM_W-1:0]        tail_sum;
    logic [SLOT_W-1:0]       tail;
    logic [SLOT_W-1:0]       head_inc;
    logic signed [CNT_W-1:0] cnt_new;
    logic [SLOT_W-1:0]       head_new;
    logic [FILL_W-1:0]       fill_new;
    logic [STATUS_W-1:0]     st_new;
    logic                    wv_new;
    logic                    q_we;
    logic                    h_we;
    logic [HADDR_W-1:0]      h_waddr;
    logic [HOLD_W-1:0]       h_wdata;
    logic [RES_W-1:0]        in_rsel;

    assign rsel    = res_reg[RES_W-1:0];
    assign in_rsel = in_resource[RES_W-1:0];
    assign res_ok  = (res_reg < rc_reg) && ({1'b0, res_reg} < (RES_FW + 1)'(NUM_RESOURCES));
    assign is_req  = (func_reg == FN_REQUEST);
    assign cur_cnt  = cnt_reg[rsel];
    assign cur_head = head_reg[rsel];
    assign cur_fill = fill_reg[rsel];
    assign pid_ok   = ({1'b0, pid_reg} < (PID_FW + 1)'(MAX_PIDS));
    assign wpid_ok  = ({1'b0, qrd_reg} < (PID_FW + 1)'(MAX_PIDS));

    // count, queue pointer and wake decisions
    assign grant    = (cur_cnt > CNT_ZERO);
    assign full     = (cur_fill == FILL_W'(QUEUE_DEPTH));
    assign inc_cnt  = (cur_cnt < CNT_MAX) ? cur_cnt + CNT_ONE : cur_cnt;
    assign wake     = (inc_cnt <= CNT_ZERO) && (cur_fill != '0);
    assign tail_sum = SUM_W'(cur_head) + SUM_W'(cur_fill);
    assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      SLOT_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : SLOT_W'(tail_sum);
    assign head_inc = (cur_head == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + SLOT_W'(1);

    always_comb
    begin
        cnt_new  = cur_cnt;
        head_new = cur_head;
        fill_new = cur_fill;
        st_new   = ST_GRANTED;
        wv_new   = 1'b0;
        q_we     = 1'b0;
        if (!res_ok)
        begin
            st_new = ST_INVALID;
        end
        else if (is_req)
        begin
            if (grant)
            begin
                cnt_new = cur_cnt - CNT_ONE;
            end
            else if (full)
            begin
                st_new = ST_FULL;
            end
            else
            begin
                cnt_new  = (cur_cnt == CNT_MIN) ? CNT_MIN : cur_cnt - CNT_ONE;
                fill_new = cur_fill + FILL_W'(1);
                st_new   = ST_BLOCKED;
                q_we     = cmd.commit;
            end
        end
        else
        begin
            cnt_new = inc_cnt;
            if (wake)
            begin
                wv_new   = 1'b1;
                head_new = head_inc;
                fill_new = cur_fill - FILL_W'(1);
            end
        end
    end

    // hold memory write port: clearing pass, evaluation, wake
    always_comb
    begin
        h_we    = 1'b0;
        h_waddr = {pid_reg[PID_W-1:0], rsel};
        h_wdata = hrd_a_reg;
        if (cmd.clear_en)
        begin
            h_we    = 1'b1;
            h_waddr = clr_addr_reg;
            h_wdata = '0;
        end
        else if (cmd.wake_write)
        begin
            h_we    = 1'b1;
            h_waddr = {qrd_reg[PID_W-1:0], rsel};
            h_wdata = hold_up(hrd_b_reg);
        end
        else if (cmd.commit && res_ok && pid_ok)
        begin
            if (is_req)
            begin
                h_we    = grant;
                h_wdata = hold_up(hrd_a_reg);
            end
            else if (wake && (qrd_reg == pid_reg))
            begin
                // woken and releasing process are the same: up then down
                h_we    = 1'b1;
                h_wdata = (hrd_a_reg == HOLD_MAX) ? HOLD_MAX - HOLD_W'(1) : hrd_a_reg;
            end
            else
            begin
                h_we    = 1'b1;
                h_wdata = hold_down(hrd_a_reg);
            end
        end
    end

    // status to the controller
    assign status.clear_last  = (clr_addr_reg == HADDR_W'(HOLD_DEPTH - 1));
    assign status.out_free    = !out_valid_reg || rsp_ready;
    assign status.wake_needed = !is_req && res_ok && wake && wpid_ok && (qrd_reg != pid_reg);

    // per-semaphore state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg <= RC_RESET;
            for (int i = 0; i < NUM_RESOURCES; i++)
            begin
                cnt_reg[i]  <= CNT_ZERO;
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_RESOURCE_COUNT)
            begin
                rc_reg <= cfg_data[RC_W-1:0];
            end
            else if (cfg_index == CFG_INITIAL_COUNTS)
            begin
                for (int i = 0; i < NUM_RESOURCES; i++)
                begin
                    if (i < INIT_FIELDS)
                    begin
                        cnt_reg[i] <= CNT_W'(cfg_data[INIT_FW*(i % INIT_FIELDS) +: INIT_FW]);
                    end
                    else
                    begin
                        cnt_reg[i] <= CNT_ZERO;
                    end
                end
            end
        end
        else if (cmd.commit && res_ok)
        begin
            cnt_reg[rsel]  <= cnt_new;
            head_reg[rsel] <= head_new;
            fill_reg[rsel] <= fill_new;
        end
    end

    // clearing pass address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_en)
        begin
            clr_addr_reg <= clr_addr_reg + HADDR_W'(1);
        end
    end

    // capture of the accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= in_func;
            pid_reg  <= in_pid;
            res_reg  <= in_resource;
        end
    end

    // wait queue memory: tail write, head read at accept
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            qmem[{rsel, tail}] <= pid_reg;
        end
        if (cmd.accept)
        begin
            qrd_reg <= qmem[{in_rsel, head_reg[in_rsel]}];
        end
    end

    // hold count memory: one write, reads for the issuer and the woken process
    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            hmem[h_waddr] <= h_wdata;
        end
        if (cmd.accept)
        begin
            hrd_a_reg <= hmem[{in_pid[PID_W-1:0], in_rsel}];
        end
        if (cmd.commit)
        begin
            hrd_b_reg <= hmem[{qrd_reg[PID_W-1:0], rsel}];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_status_reg <= st_new;
            out_wv_reg     <= wv_new;
            out_wpid_reg   <= wv_new ? qrd_reg : '0;
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign rsp_status      = out_status_reg;
    assign rsp_woken_valid = out_wv_reg;
    assign rsp_woken_pid   = out_wpid_reg;

endmodule

FILE: rtl/core/csb_checker.sv
// port-level checks of the counting semaphore bank and their binding
`include "assert_macros.svh"

module csb_checker
    import csb_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic                rsp_woken_valid,
    input logic [PID_FW-1:0]   rsp_woken_pid
);

    // one operation at a time: no accept on the cycle after an accept
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready, "accept right after accept")

    // clearing pass keeps the input closed right after reset
    `ASSERT_IMPL(a_closed_after_reset, clk, rst_n, !$past(rst_n), !cmd_ready, "ready during clearing pass")

    // a stalled result beat holds
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_woken_valid) && $stable(rsp_woken_pid), "result beat changed under stall")

    // a wake comes only with a granted release, and a beat without a wake carries a zero id
    `ASSERT_IMPL(a_wake_fields, clk, rst_n, rsp_valid, (rsp_woken_valid && rsp_status == ST_GRANTED) || (!rsp_woken_valid && rsp_woken_pid == '0), "inconsistent wake fields")

endmodule

bind counting_semaphore_bank csb_checker u_csb_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_woken_valid (rsp.woken_valid),
    .rsp_woken_pid   (rsp.woken_pid)
);

FILE: dv/tb_counting_semaphore_bank.sv
// self-checking testbench of the counting semaphore bank
`timescale 1ns / 1ps

module tb_counting_semaphore_bank;
    import csb_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int QUIET_LIMIT    = 5000;
    localparam int PHASES         = 8;
    localparam int PHASE_BUDGET   = 180;
    localparam int STORM_RELEASES = 280;
    localparam int HOLD_REQUESTS  = 270;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PID_FW-1:0] pid;
        logic [RES_FW-1:0] resource;
    } sem_op_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                woken_valid;
        logic [PID_FW-1:0]   woken_pid;
    } sem_reply_t;

    typedef enum int {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    csb_in_if  cmd_ch ();
    csb_out_if rsp_ch ();

    counting_semaphore_bank u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // stimulus and scoreboard storage
    sem_op_t    op_backlog[$];
    sem_reply_t replies_due[$];
    sem_op_t    next_op;
    pace_t      pace = PACE_FREE;
    logic [RC_W-1:0] active_rc = RC_RESET;

    int error_count = 0;
    int ops_taken   = 0;
    int beats_seen  = 0;
    int wake_count  = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int quiet_cycles = 0;

    // predicted state of the bank (hold counts never reach the ports)
    logic [RC_W-1:0]         model_rc;
    logic [CFG_DATA_W-1:0]   model_init;
    logic signed [CNT_W-1:0] sem_level[DEF_NUM_RESOURCES];
    logic [PID_FW-1:0]       waiters[DEF_NUM_RESOURCES][DEF_QUEUE_DEPTH];
    int                      wait_head[DEF_NUM_RESOURCES];
    int                      wait_fill[DEF_NUM_RESOURCES];

    function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] value);
        if (idx == CFG_RESOURCE_COUNT)
            model_rc = value[RC_W-1:0];
        else if (idx == CFG_INITIAL_COUNTS) begin
            model_init = value;
            // reload every count, queues stay as they are
            for (int i = 0; i < DEF_NUM_RESOURCES; i++)
                sem_level[i] = model_init[INIT_FW*i +: INIT_FW];
        end
    endfunction

    function automatic sem_reply_t step_semaphores(sem_op_t op);
        sem_reply_t reply;
        int         lvl;
        int         slot;
        int         r;
        reply = '{status: ST_GRANTED, woken_valid: 1'b0, woken_pid: '0};
        r = op.resource;
        if (op.resource >= model_rc || r >= DEF_NUM_RESOURCES)
            reply.status = ST_INVALID;
        else if (op.func == FN_REQUEST) begin
            lvl = int'(sem_level[r]) - 1;
            if (lvl >= 0)
                sem_level[r] = lvl[CNT_W-1:0];
            else if (wait_fill[r] >= DEF_QUEUE_DEPTH)
                reply.status = ST_FULL;
            else begin
                // append the requester to the tail of this semaphore's queue
                slot = (wait_head[r] + wait_fill[r]) % DEF_QUEUE_DEPTH;
                sem_level[r] = (lvl < int'(CNT_MIN)) ? CNT_MIN : lvl[CNT_W-1:0];
                waiters[r][slot] = op.pid;
                wait_fill[r]++;
                reply.status = ST_BLOCKED;
            end
        end
        else begin
            // release: saturating increment, then wake the head if still owed
            lvl = int'(sem_level[r]);
            if (lvl < int'(CNT_MAX))
                lvl++;
            sem_level[r] = lvl[CNT_W-1:0];
            if (lvl <= 0 && wait_fill[r] > 0) begin
                reply.woken_valid = 1'b1;
                reply.woken_pid   = waiters[r][wait_head[r]];
                wait_head[r]      = (wait_head[r] + 1) % DEF_QUEUE_DEPTH;
                wait_fill[r]--;
            end
        end
        return reply;
    endfunction

    function automatic bit sender_pauses();
        if (pace == PACE_SENDER)
            return $urandom_range(0, 99) < 60;
        if (pace == PACE_BOTH)
            return $urandom_range(0, 99) < 31;
        return 1'b0;
    endfunction

    function automatic bit receiver_stalls();
        if (pace == PACE_RECEIVER)
            return $urandom_range(0, 99) < 60;
        if (pace == PACE_BOTH)
            return $urandom_range(0, 99) < 31;
        return 1'b0;
    endfunction

    function automatic sem_op_t any_op();
        sem_op_t op;
        op.func = $urandom_range(0, 1) ? FN_RELEASE : FN_REQUEST;
        op.pid  = $urandom_range(0, 1) ? PID_FW'($urandom_range(0, 3))
                                       : PID_FW'($urandom_range(0, 63));
        if (active_rc != 0 && $urandom_range(0, 99) < 80)
            op.resource = RES_FW'($urandom_range(0, active_rc - 1));
        else
            op.resource = RES_FW'($urandom_range(0, 15));
        return op;
    endfunction

    task automatic enqueue(logic [FUNC_W-1:0] func, int pid, int res);
        sem_op_t op;
        op.func     = func;
        op.pid      = PID_FW'(pid);
        op.resource = RES_FW'(res);
        op_backlog.push_back(op);
    endtask

    task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // wait until every queued beat went in and every reply came back
    task automatic drain(int settle);
        do
            @(posedge clk);
        while (op_backlog.size() != 0 || cmd_ch.valid || replies_due.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    // command driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cmd_ch.valid    <= 1'b0;
            cmd_ch.func     <= FN_REQUEST;
            cmd_ch.pid      <= '0;
            cmd_ch.resource <= '0;
        end
        else if (!cmd_ch.valid || cmd_ch.ready) begin
            if (op_backlog.size() != 0 && !sender_pauses()) begin
                next_op = op_backlog.pop_front();
                cmd_ch.valid    <= 1'b1;
                cmd_ch.func     <= next_op.func;
                cmd_ch.pid      <= next_op.pid;
                cmd_ch.resource <= next_op.resource;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // reply backpressure
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= !receiver_stalls();
    end

    // monitor: track settings, predict accepted beats, check reply beats
    always @(posedge clk or negedge rst_n) begin
        sem_op_t    seen_op;
        sem_reply_t want;
        if (!rst_n) begin
            model_rc   = RC_RESET;
            model_init = '0;
            for (int i = 0; i < DEF_NUM_RESOURCES; i++) begin
                sem_level[i] = CNT_ZERO;
                wait_head[i] = 0;
                wait_fill[i] = 0;
            end
        end
        else begin
            if (cfg_we)
                apply_setting(cfg_index, cfg_data);
            if (cmd_ch.valid && cmd_ch.ready) begin
                seen_op = '{func: cmd_ch.func, pid: cmd_ch.pid, resource: cmd_ch.resource};
                replies_due.push_back(step_semaphores(seen_op));
                ops_taken++;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                beats_seen++;
                if (replies_due.size() == 0) begin
                    $error("reply beat with no outstanding operation");
                    error_count++;
                end
                else begin
                    want = replies_due.pop_front();
                    status_seen[want.status]++;
                    if (want.woken_valid)
                        wake_count++;
                    if (rsp_ch.status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, rsp_ch.status);
                        error_count++;
                    end
                    if (rsp_ch.woken_valid !== want.woken_valid) begin
                        $error("woken_valid mismatch: expected %0d, got %0d",
                               want.woken_valid, rsp_ch.woken_valid);
                        error_count++;
                    end
                    if (rsp_ch.woken_pid !== want.woken_pid) begin
                        $error("woken_pid mismatch: expected %0d, got %0d",
                               want.woken_pid, rsp_ch.woken_pid);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no accepted beat on either channel
    always @(posedge clk) begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // test sequence
    initial begin
        int phase;
        int budget;
        int planned;
        int run;
        int r;
        logic [CFG_DATA_W-1:0] counts_sel;

        cfg_we          = 1'b0;
        cfg_index       = CFG_RESOURCE_COUNT;
        cfg_data        = '0;
        rst_n           = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // hold count clearing pass keeps the command side closed
        do
            @(posedge clk);
        while (!cmd_ch.ready);

        // directed: grant, block, wake in order, invalid indexes, empty release
        write_setting(CFG_RESOURCE_COUNT, 64'd8);
        write_setting(CFG_INITIAL_COUNTS, 64'h0000_0000_00FF_0001);
        active_rc = 4'd8;
        @(negedge clk);
        enqueue(FN_REQUEST, 0, 0);
        enqueue(FN_REQUEST, 63, 0);
        enqueue(FN_REQUEST, 1, 0);
        enqueue(FN_RELEASE, 0, 0);
        enqueue(FN_RELEASE, 0, 0);
        enqueue(FN_RELEASE, 5, 0);
        enqueue(FN_REQUEST, 2, 1);
        enqueue(FN_RELEASE, 2, 1);
        enqueue(FN_REQUEST, 62, 2);
        enqueue(FN_RELEASE, 62, 2);
        enqueue(FN_REQUEST, 9, 8);
        enqueue(FN_RELEASE, 63, 15);
        enqueue(FN_REQUEST, 0, 7);
        enqueue(FN_RELEASE, 3, 7);
        enqueue(FN_RELEASE, 42, 3);
        enqueue(FN_REQUEST, 21, 3);
        enqueue(FN_REQUEST, 10, 0);
        enqueue(FN_REQUEST, 11, 0);
        drain(4);

        // reload counts with a waiter still queued, shrink the bank
        write_setting(CFG_RESOURCE_COUNT, 64'd3);
        write_setting(CFG_INITIAL_COUNTS, 64'h0202_0202_0202_0202);
        active_rc = 4'd3;
        @(negedge clk);
        enqueue(FN_RELEASE, 4, 0);
        enqueue(FN_REQUEST, 1, 3);
        enqueue(FN_REQUEST, 1, 2);
        enqueue(FN_RELEASE, 1, 2);

        // random phases, each with its own setting and pacing
        for (phase = 0; phase < PHASES; phase++) begin
            drain(4);
            counts_sel = {$urandom, $urandom};
            case (phase)
                0: begin active_rc = 4'd8; counts_sel = '0; end
                1: begin active_rc = 4'd8; counts_sel = '1; end
                2: active_rc = 4'd0;
                3: active_rc = RC_W'($urandom_range(1, 7));
                5: active_rc = 4'd1;
                default: active_rc = RC_W'($urandom_range(1, 8));
            endcase
            // small counts so that queues fill up
            if (phase >= 4)
                for (int i = 0; i < INIT_FIELDS; i++)
                    counts_sel[INIT_FW*i +: INIT_FW] = INIT_FW'($urandom_range(0, 3));
            write_setting(CFG_RESOURCE_COUNT, CFG_DATA_W'(active_rc));
            write_setting(CFG_INITIAL_COUNTS, counts_sel);
            budget = (active_rc == 0) ? 40 : PHASE_BUDGET;

            @(negedge clk);
            pace = pace_t'(phase % 4);
            if (phase == 1) begin
                // drive one count into saturation, then pile holds onto one process
                r = $urandom_range(0, 7);
                for (int k = 0; k < STORM_RELEASES; k++)
                    enqueue(FN_RELEASE, $urandom_range(0, 63), r);
                for (int k = 0; k < HOLD_REQUESTS; k++)
                    enqueue(FN_REQUEST, 7, r);
            end
            planned = 0;
            while (planned < budget) begin
                if (active_rc != 0 && $urandom_range(0, 99) < 20) begin
                    // flood one semaphore with requests, which can pass queue depth, then release as many
                    r   = $urandom_range(0, active_rc - 1);
                    run = $urandom_range(60, 70);
                    for (int k = 0; k < run; k++)
                        enqueue(FN_REQUEST, $urandom_range(0, 63), r);
                    for (int k = 0; k < run; k++)
                        enqueue(FN_RELEASE, $urandom_range(0, 63), r);
                    planned += 2 * run;
                end
                else begin
                    run = $urandom_range(10, 40);
                    for (int k = 0; k < run; k++)
                        op_backlog.push_back(any_op());
                    planned += run;
                end
            end
        end

        drain(10);
        $display("%0d operations checked over %0d setting phases: %0d granted, %0d blocked,",
                 beats_seen, PHASES, status_seen[ST_GRANTED], status_seen[ST_BLOCKED]);
        $display("%0d invalid, %0d queue full, %0d waiters woken",
                 status_seen[ST_INVALID], status_seen[ST_FULL], wake_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/csb_pkg.sv
rtl/core/csb_if.sv
rtl/core/csb_ctrl.sv
rtl/core/csb_datapath.sv
rtl/core/counting_semaphore_bank.sv
rtl/core/csb_checker.sv
dv/tb_counting_semaphore_bank.sv
